// ----- design/assert_macros.svh -----
// Assertion macros used by the projector core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check on the design clock and reset.
`define ASSERT_CORE(label, prop, msg) \
    `ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

// ----- design/qcvp_pkg.sv -----
// Types and constants of the quaternion cube vertex projector.
package qcvp_pkg;

    localparam int QW    = 16;
    localparam int PW    = 32;
    localparam int MW    = 34;
    localparam int RW    = 35;
    localparam int SW    = 8;
    localparam int CW    = 10;
    localparam int PRODW = RW + SW + 1;
    localparam int NW    = PRODW + 1;
    localparam int FRAC  = 28;
    localparam int OW    = 12;
    localparam int KW    = 3;
    localparam int NCORNER = 8;
    localparam int PAW   = 4;
    localparam int DW    = 32;

    localparam int OUT_MIN = -2048;
    localparam int OUT_MAX = 2047;

    localparam logic signed [MW-1:0] ONE_Q = MW'(1) << FRAC;
    localparam logic [KW-1:0] LAST_CORNER = KW'(NCORNER - 1);

    localparam logic [CW-1:0] CENTER_X_RST    = CW'(160);
    localparam logic [CW-1:0] CENTER_Y_RST    = CW'(120);
    localparam logic [SW-1:0] PIXEL_SCALE_RST = SW'(50);

    // Bit j set means coordinate j of the corner is -1, otherwise +1.
    localparam logic [2:0] CORNER_NEG [NCORNER] = '{
        3'b111, 3'b110, 3'b100, 3'b101,
        3'b011, 3'b010, 3'b000, 3'b001
    };

    typedef enum logic [1:0] {
        REG_CENTER_X    = 2'd0,
        REG_CENTER_Y    = 2'd1,
        REG_PIXEL_SCALE = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic signed [MW-1:0] m00;
        logic signed [MW-1:0] m01;
        logic signed [MW-1:0] m02;
        logic signed [MW-1:0] m10;
        logic signed [MW-1:0] m11;
        logic signed [MW-1:0] m12;
    } t_mat;

    typedef struct packed {
        logic          valid;
        logic [KW-1:0] k;
    } t_corner;

    typedef struct packed {
        logic [CW-1:0] center_x;
        logic [CW-1:0] center_y;
        logic [SW-1:0] pixel_scale;
    } t_cfg;

endpackage

// ----- design/qcvp_project.sv -----
// Corner rotation, scaling and screen projection pipeline.
module qcvp_project (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  qcvp_pkg::t_corner               i_corner,
    input  qcvp_pkg::t_mat                  i_mat,
    input  qcvp_pkg::t_cfg                  i_cfg,
    output logic                            o_valid,
    output logic [qcvp_pkg::KW-1:0]         o_vertex_index,
    output logic signed [qcvp_pkg::OW-1:0]  o_screen_x,
    output logic signed [qcvp_pkg::OW-1:0]  o_screen_y,
    output logic                            o_last
);

    function automatic logic signed [qcvp_pkg::RW-1:0] term(
        input logic signed [qcvp_pkg::MW-1:0] m,
        input logic                           neg
    );
        logic signed [qcvp_pkg::RW-1:0] e;
        e = {{(qcvp_pkg::RW-qcvp_pkg::MW){m[qcvp_pkg::MW-1]}}, m};
        return neg ? -e : e;
    endfunction

    // Divide by 2^FRAC rounding toward zero, then clamp to the output range.
    function automatic logic signed [qcvp_pkg::OW-1:0] trunc_sat(
        input logic signed [qcvp_pkg::NW-1:0] v
    );
        logic signed [qcvp_pkg::NW-qcvp_pkg::FRAC-1:0] q;
        q = v[qcvp_pkg::NW-1:qcvp_pkg::FRAC];
        if (v[qcvp_pkg::NW-1] && (v[qcvp_pkg::FRAC-1:0] != '0)) begin
            q = q + 1'b1;
        end
        if (q < qcvp_pkg::OUT_MIN) begin
            return qcvp_pkg::OW'(qcvp_pkg::OUT_MIN);
        end else if (q > qcvp_pkg::OUT_MAX) begin
            return qcvp_pkg::OW'(qcvp_pkg::OUT_MAX);
        end
        return q[qcvp_pkg::OW-1:0];
    endfunction

    logic                              r_b1_v;
    logic [qcvp_pkg::KW-1:0]           r_b1_k;
    logic signed [qcvp_pkg::RW-1:0]    r_rx;
    logic signed [qcvp_pkg::RW-1:0]    r_ry;
    logic                              r_b2_v;
    logic [qcvp_pkg::KW-1:0]           r_b2_k;
    logic signed [qcvp_pkg::PRODW-1:0] r_px;
    logic signed [qcvp_pkg::PRODW-1:0] r_py;

    logic [2:0]                        neg;
    logic signed [qcvp_pkg::RW-1:0]    n_rx;
    logic signed [qcvp_pkg::RW-1:0]    n_ry;
    logic signed [qcvp_pkg::SW:0]      scale_s;
    logic signed [qcvp_pkg::NW-1:0]    cx_q;
    logic signed [qcvp_pkg::NW-1:0]    cy_q;
    logic signed [qcvp_pkg::NW-1:0]    nx;
    logic signed [qcvp_pkg::NW-1:0]    ny;

    always_comb begin
        neg  = qcvp_pkg::CORNER_NEG[i_corner.k];
        n_rx = term(i_mat.m00, neg[0]) + term(i_mat.m01, neg[1]) + term(i_mat.m02, neg[2]);
        n_ry = term(i_mat.m10, neg[0]) + term(i_mat.m11, neg[1]) + term(i_mat.m12, neg[2]);
        scale_s = {1'b0, i_cfg.pixel_scale};
        cx_q = {{(qcvp_pkg::NW-qcvp_pkg::CW-qcvp_pkg::FRAC){1'b0}},
                i_cfg.center_x, {qcvp_pkg::FRAC{1'b0}}};
        cy_q = {{(qcvp_pkg::NW-qcvp_pkg::CW-qcvp_pkg::FRAC){1'b0}},
                i_cfg.center_y, {qcvp_pkg::FRAC{1'b0}}};
        nx = cx_q + {{(qcvp_pkg::NW-qcvp_pkg::PRODW){r_px[qcvp_pkg::PRODW-1]}}, r_px};
        ny = cy_q - {{(qcvp_pkg::NW-qcvp_pkg::PRODW){r_py[qcvp_pkg::PRODW-1]}}, r_py};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v  <= 1'b0;
            r_b2_v  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_b1_v  <= i_corner.valid;
            r_b2_v  <= r_b1_v;
            o_valid <= r_b2_v;
        end
        r_b1_k         <= i_corner.k;
        r_rx           <= n_rx;
        r_ry           <= n_ry;
        r_b2_k         <= r_b1_k;
        r_px           <= scale_s * r_rx;
        r_py           <= scale_s * r_ry;
        o_vertex_index <= r_b2_k;
        o_screen_x     <= trunc_sat(nx);
        o_screen_y     <= trunc_sat(ny);
        o_last         <= (r_b2_k == qcvp_pkg::LAST_CORNER);
    end

endmodule

// ----- design/quaternion_cube_vertex_projector_core.sv -----
// Top level of the quaternion cube vertex projector with its register port.
//
// Each beat on start carries one orientation quaternion and yields eight
// projected cube corners, one per cycle, corner 0 first and o_last on
// corner 7. The first corner passes the input, product and matrix registers
// and the rotation, scaling and output registers. The corner sequencer
// over the eight corners of one matrix sets throughput; up to two further
// quaternions wait in the input and product registers, and busy rises when
// both are full and the matrix slot is not freeing. Results are not held:
// each one stands on the ports for exactly one cycle while o_valid is high.

`include "assert_macros.svh"

module quaternion_cube_vertex_projector_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [qcvp_pkg::PAW-1:0]            paddr,
    input  logic [qcvp_pkg::DW-1:0]             pwdata,
    output logic [qcvp_pkg::DW-1:0]             prdata,
    output logic                                pready,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [qcvp_pkg::QW-1:0]      i_quat_w,
    input  logic signed [qcvp_pkg::QW-1:0]      i_quat_x,
    input  logic signed [qcvp_pkg::QW-1:0]      i_quat_y,
    input  logic signed [qcvp_pkg::QW-1:0]      i_quat_z,
    output logic                                o_valid,
    output logic [qcvp_pkg::KW-1:0]             o_vertex_index,
    output logic signed [qcvp_pkg::OW-1:0]      o_screen_x,
    output logic signed [qcvp_pkg::OW-1:0]      o_screen_y,
    output logic                                o_last
);

    function automatic logic signed [qcvp_pkg::MW-1:0] ext_p(
        input logic signed [qcvp_pkg::PW-1:0] p
    );
        return {{(qcvp_pkg::MW-qcvp_pkg::PW){p[qcvp_pkg::PW-1]}}, p};
    endfunction

    logic [qcvp_pkg::CW-1:0] r_center_x;
    logic [qcvp_pkg::CW-1:0] r_center_y;
    logic [qcvp_pkg::SW-1:0] r_pixel_scale;

    logic                           r_q_v;
    logic signed [qcvp_pkg::QW-1:0] r_qw;
    logic signed [qcvp_pkg::QW-1:0] r_qa;
    logic signed [qcvp_pkg::QW-1:0] r_qb;
    logic signed [qcvp_pkg::QW-1:0] r_qc;

    logic                           r_p_v;
    logic signed [qcvp_pkg::PW-1:0] r_aa;
    logic signed [qcvp_pkg::PW-1:0] r_bb;
    logic signed [qcvp_pkg::PW-1:0] r_cc;
    logic signed [qcvp_pkg::PW-1:0] r_ab;
    logic signed [qcvp_pkg::PW-1:0] r_wc;
    logic signed [qcvp_pkg::PW-1:0] r_ac;
    logic signed [qcvp_pkg::PW-1:0] r_wb;
    logic signed [qcvp_pkg::PW-1:0] r_bc;
    logic signed [qcvp_pkg::PW-1:0] r_wa;

    logic                    r_m_v;
    logic [qcvp_pkg::KW-1:0] r_k;
    qcvp_pkg::t_mat          r_mat;

    qcvp_pkg::t_mat    n_mat;
    qcvp_pkg::t_corner corner;
    qcvp_pkg::t_cfg    cfg;
    logic              cfg_wr;
    logic              accept;
    logic              m_free;
    logic              load_m;
    logic              adv_p;
    logic              load_p;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (qcvp_pkg::t_reg_idx'(paddr[qcvp_pkg::PAW-1:2]))
            qcvp_pkg::REG_CENTER_X:    prdata = qcvp_pkg::DW'(r_center_x);
            qcvp_pkg::REG_CENTER_Y:    prdata = qcvp_pkg::DW'(r_center_y);
            qcvp_pkg::REG_PIXEL_SCALE: prdata = qcvp_pkg::DW'(r_pixel_scale);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x    <= qcvp_pkg::CENTER_X_RST;
            r_center_y    <= qcvp_pkg::CENTER_Y_RST;
            r_pixel_scale <= qcvp_pkg::PIXEL_SCALE_RST;
        end else if (cfg_wr) begin
            unique case (qcvp_pkg::t_reg_idx'(paddr[qcvp_pkg::PAW-1:2]))
                qcvp_pkg::REG_CENTER_X:    r_center_x    <= pwdata[qcvp_pkg::CW-1:0];
                qcvp_pkg::REG_CENTER_Y:    r_center_y    <= pwdata[qcvp_pkg::CW-1:0];
                qcvp_pkg::REG_PIXEL_SCALE: r_pixel_scale <= pwdata[qcvp_pkg::SW-1:0];
                default: ;
            endcase
        end
    end

    // The matrix slot frees as its last corner goes out.
    assign m_free = !r_m_v || (r_k == qcvp_pkg::LAST_CORNER);
    assign load_m = r_p_v && m_free;
    assign adv_p  = !r_p_v || load_m;
    assign load_p = r_q_v && adv_p;
    assign busy   = r_q_v && !adv_p;
    assign accept = start && !busy;

    always_comb begin
        n_mat.m00 = qcvp_pkg::ONE_Q - ((ext_p(r_bb) + ext_p(r_cc)) <<< 1);
        n_mat.m01 = (ext_p(r_ab) - ext_p(r_wc)) <<< 1;
        n_mat.m02 = (ext_p(r_ac) + ext_p(r_wb)) <<< 1;
        n_mat.m10 = (ext_p(r_ab) + ext_p(r_wc)) <<< 1;
        n_mat.m11 = qcvp_pkg::ONE_Q - ((ext_p(r_aa) + ext_p(r_cc)) <<< 1);
        n_mat.m12 = (ext_p(r_bc) - ext_p(r_wa)) <<< 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_v <= 1'b0;
            r_p_v <= 1'b0;
            r_m_v <= 1'b0;
            r_k   <= '0;
        end else begin
            if (accept) begin
                r_q_v <= 1'b1;
            end else if (load_p) begin
                r_q_v <= 1'b0;
            end
            if (load_p) begin
                r_p_v <= 1'b1;
            end else if (load_m) begin
                r_p_v <= 1'b0;
            end
            if (load_m) begin
                r_m_v <= 1'b1;
                r_k   <= '0;
            end else if (r_m_v) begin
                if (r_k == qcvp_pkg::LAST_CORNER) begin
                    r_m_v <= 1'b0;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
        end
        if (accept) begin
            r_qw <= i_quat_w;
            r_qa <= i_quat_x;
            r_qb <= i_quat_y;
            r_qc <= i_quat_z;
        end
        if (load_p) begin
            r_aa <= r_qa * r_qa;
            r_bb <= r_qb * r_qb;
            r_cc <= r_qc * r_qc;
            r_ab <= r_qa * r_qb;
            r_wc <= r_qw * r_qc;
            r_ac <= r_qa * r_qc;
            r_wb <= r_qw * r_qb;
            r_bc <= r_qb * r_qc;
            r_wa <= r_qw * r_qa;
        end
        if (load_m) begin
            r_mat <= n_mat;
        end
    end

    assign corner.valid    = r_m_v;
    assign corner.k        = r_k;
    assign cfg.center_x    = r_center_x;
    assign cfg.center_y    = r_center_y;
    assign cfg.pixel_scale = r_pixel_scale;

    qcvp_project u_project (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_corner       (corner),
        .i_mat          (r_mat),
        .i_cfg          (cfg),
        .o_valid        (o_valid),
        .o_vertex_index (o_vertex_index),
        .o_screen_x     (o_screen_x),
        .o_screen_y     (o_screen_y),
        .o_last         (o_last)
    );

    // A run of eight corners goes out without a gap.
    `ASSERT_CORE(a_run_contiguous, o_valid && !o_last |=> o_valid, "corner run broken")

    // A new run starts only after the previous one ended.
    `ASSERT_CORE(a_run_start, o_valid && o_vertex_index == '0 |-> $past(!o_valid || o_last), "run started mid-run")

    // The matrix under the sequencer does not change until its last corner.
    `ASSERT_CORE(a_mat_hold, r_m_v && r_k != qcvp_pkg::LAST_CORNER |=> $stable(r_mat), "matrix overwritten")

endmodule
